// ===== rtl/mbp_pkg.sv =====
`default_nettype none

package mbp_pkg;

    localparam int ValueWidth = 64;
    localparam int CountWidth = 7;
    localparam int ByteCntWidth = 3;
    localparam int MaxBits = 64;
    localparam int MaxBytes = 4;

    localparam logic [1:0] ACT_WRITE_BITS = 2'd0;
    localparam logic [1:0] ACT_WRITE_BYTES = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        KIND_BITS,
        KIND_BYTES,
        KIND_FLUSH
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [CountWidth-1:0]  cnt;
        logic [ValueWidth-1:0]  value;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/mbp_front.sv =====
`default_nettype none

module mbp_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           action,
    input  wire logic [mbp_pkg::CountWidth-1:0]       bit_count,
    input  wire logic [mbp_pkg::ByteCntWidth-1:0]     byte_count,
    input  wire logic [mbp_pkg::ValueWidth-1:0]       value,
    output logic                                      cmd_valid,
    input  wire logic                                 cmd_ready,
    output mbp_pkg::cmd_t                             cmd
);
    import mbp_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    cmd_t                      cmd_reg;
    cmd_t                      cmd_next;
    logic                      keep;
    logic [CountWidth-1:0]     nbits;
    logic [CountWidth-1:0]     lshift;
    logic [ByteCntWidth-1:0]   nbytes;
    logic                      in_fire;
    logic                      push;

    assign push     = valid_reg && cmd_ready;
    assign in_ready = !valid_reg || cmd_ready;
    assign in_fire  = in_valid && in_ready;

    // saturate counts and left-align bit fields
    always_comb
    begin
        nbits  = (bit_count > CountWidth'(MaxBits)) ? CountWidth'(MaxBits) : bit_count;
        lshift = CountWidth'(MaxBits) - nbits;
        nbytes = (byte_count > ByteCntWidth'(MaxBytes)) ? ByteCntWidth'(MaxBytes)
                                                         : byte_count;
        keep     = 1'b0;
        cmd_next = cmd_reg;
        unique case (action)
            ACT_WRITE_BITS:
            begin
                keep           = (nbits != '0);
                cmd_next.kind  = KIND_BITS;
                cmd_next.cnt   = nbits;
                cmd_next.value = value << lshift[5:0];
            end
            ACT_WRITE_BYTES:
            begin
                keep           = 1'b1;
                cmd_next.kind  = KIND_BYTES;
                cmd_next.cnt   = CountWidth'(nbytes);
                cmd_next.value = value;
            end
            ACT_FLUSH:
            begin
                keep           = 1'b1;
                cmd_next.kind  = KIND_FLUSH;
                cmd_next.cnt   = '0;
                cmd_next.value = value;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (in_fire)
        begin
            valid_next = keep;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

// ===== rtl/mbp_queue.sv =====
`default_nettype none

module mbp_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mbp_pkg::cmd_t  in_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mbp_pkg::cmd_t       out_cmd
);
    import mbp_pkg::*;

    localparam int PtrWidth = $clog2(DEPTH);
    localparam int CntWidth = $clog2(DEPTH + 1);

    cmd_t                 mem_reg [DEPTH];
    logic [PtrWidth-1:0]  wr_ptr_reg;
    logic [PtrWidth-1:0]  wr_ptr_next;
    logic [PtrWidth-1:0]  rd_ptr_reg;
    logic [PtrWidth-1:0]  rd_ptr_next;
    logic [CntWidth-1:0]  count_reg;
    logic [CntWidth-1:0]  count_next;
    logic                 wr_en;
    logic                 rd_en;

    assign in_ready  = (count_reg != CntWidth'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbp_back.sv =====
`default_nettype none

module mbp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire mbp_pkg::cmd_t  cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import mbp_pkg::*;

    logic                   busy_reg;
    logic                   busy_next;
    kind_t                  kind_reg;
    logic [CountWidth-1:0]  cnt_reg;
    logic [CountWidth-1:0]  cnt_next;
    logic [ValueWidth-1:0]  val_reg;
    logic [ValueWidth-1:0]  val_next;
    logic [7:0]             pbyte_reg;
    logic [7:0]             pbyte_next;
    logic [2:0]             pbits_reg;
    logic [2:0]             pbits_next;
    logic                   ovalid_reg;
    logic                   ovalid_next;
    logic [7:0]             obyte_reg;
    logic [7:0]             obyte_next;
    logic                   olast_reg;
    logic                   olast_next;
    logic                   out_free;
    logic                   step;
    logic                   emit;
    logic [3:0]             room;
    logic [3:0]             chunk;
    logic [3:0]             fill;
    logic [7:0]             mask;
    logic [7:0]             merged;
    logic [CountWidth-1:0]  cnt_left;

    assign out_free  = !ovalid_reg || out_ready;
    assign step      = busy_reg && out_free;
    assign cmd_ready = !busy_reg;

    // bit insertion: up to one byte's room per cycle while the output is free
    always_comb
    begin
        room     = 4'd8 - {1'b0, pbits_reg};
        chunk    = (cnt_reg < CountWidth'(room)) ? cnt_reg[3:0] : room;
        fill     = {1'b0, pbits_reg} + chunk;
        mask     = (8'hFF >> pbits_reg) & ~(8'hFF >> fill);
        merged   = (pbyte_reg & ~mask) | ((val_reg[ValueWidth-1 -: 8] >> pbits_reg) & mask);
        cnt_left = cnt_reg - CountWidth'(chunk);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        val_next   = val_reg;
        pbyte_next = pbyte_reg;
        pbits_next = pbits_reg;
        emit       = 1'b0;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        if (step)
        begin
            unique case (kind_reg)
                KIND_BITS:
                begin
                    pbyte_next = merged;
                    pbits_next = fill[2:0];
                    cnt_next   = cnt_left;
                    val_next   = val_reg << chunk;
                    busy_next  = (cnt_left != '0);
                    emit       = fill[3];
                    obyte_next = merged;
                    olast_next = (cnt_left < CountWidth'(8));
                end
                KIND_BYTES:
                begin
                    if (pbits_reg != '0)
                    begin
                        emit       = 1'b1;
                        obyte_next = pbyte_reg;
                        olast_next = (cnt_reg == '0);
                        pbits_next = '0;
                        busy_next  = (cnt_reg != '0);
                    end
                    else if (cnt_reg != '0)
                    begin
                        emit       = 1'b1;
                        obyte_next = val_reg[7:0];
                        olast_next = (cnt_reg == CountWidth'(1));
                        val_next   = val_reg >> 8;
                        cnt_next   = cnt_reg - 1'b1;
                        busy_next  = (cnt_reg != CountWidth'(1));
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                KIND_FLUSH:
                begin
                    emit       = (pbits_reg != '0);
                    obyte_next = pbyte_reg;
                    olast_next = 1'b1;
                    pbits_next = '0;
                    busy_next  = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (!busy_reg && cmd_valid)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.cnt;
            val_next  = cmd.value;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pbyte_reg  <= '0;
            pbits_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pbyte_reg  <= pbyte_next;
            pbits_reg  <= pbits_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && cmd_valid)
        begin
            kind_reg <= cmd.kind;
        end
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        if (emit)
        begin
            obyte_reg <= obyte_next;
            olast_reg <= olast_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

// ===== rtl/msb_first_bit_packer_unit.sv =====
`default_nettype none

// MSB-first bit packer. Requests enter on s_*: tuser selects write bits (append the low
// bit_count bits of value, highest first), write bytes (flush any partial byte, then emit
// byte_count bytes of value, low byte first) or flush. Bytes leave on m_* at most one per
// cycle, tlast marking the final byte of each request. A front stage saturates counts and
// aligns the data, a short queue of QUEUE_DEPTH requests decouples it from the back end,
// which places up to one byte's worth of bits per cycle when the output is free. The back
// end loads a request, then takes a step whenever the output is free: ceil((pending +
// bit_count) / 8) steps for write bits, one per byte emitted for write bytes and flush, and
// a single step when those emit nothing; the single output byte lane sets the rate. Write
// bits requests with a zero count and the unused action are dropped up front.
module msb_first_bit_packer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [79:0]  s_tdata,   // bit_count, byte_count, value, zero pad
    input  wire logic [1:0]   s_tuser,   // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic              m_tlast
);
    import mbp_pkg::*;

    logic  f_valid;
    logic  f_ready;
    cmd_t  f_cmd;
    logic  q_valid;
    logic  q_ready;
    cmd_t  q_cmd;

    mbp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (s_tuser),
        .bit_count  (s_tdata[6:0]),
        .byte_count (s_tdata[9:7]),
        .value      (s_tdata[73:10]),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd        (f_cmd)
    );

    mbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    mbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import mbp_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_REQUESTS = 90;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // model state of the packer
    logic [7:0]  pend_byte = 8'h00;
    int          pend_cnt = 0;

    out_byte_t   out_bytes_q[$];
    int          err_cnt = 0;
    int          idle_cnt = 0;
    int          src_gap_max = 0;
    int          snk_stall_max = 0;

    msb_first_bit_packer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic pack_request(input logic [1:0] act, input logic [6:0] nbits,
                                input logic [2:0] nbytes, input logic [63:0] val);
        int        n;
        out_byte_t res[$];
        out_byte_t b;
        n = 0;
        case (act)
            ACT_WRITE_BITS:
            begin
                n = (nbits > MaxBits) ? MaxBits : int'(nbits);
                for (int i = n - 1; i >= 0; i--)
                begin
                    pend_byte[7 - pend_cnt] = val[i];
                    pend_cnt++;
                    if (pend_cnt == 8)
                    begin
                        b.data = pend_byte;
                        b.last = 1'b0;
                        res.push_back(b);
                        pend_cnt = 0;
                    end
                end
            end
            ACT_WRITE_BYTES, ACT_FLUSH:
            begin
                if (pend_cnt != 0)
                begin
                    b.data = pend_byte;
                    b.last = 1'b0;
                    res.push_back(b);
                    pend_cnt = 0;
                end
                if (act == ACT_WRITE_BYTES)
                begin
                    n = (nbytes > MaxBytes) ? MaxBytes : int'(nbytes);
                    for (int j = 0; j < n; j++)
                    begin
                        b.data = val[8 * j +: 8];
                        b.last = 1'b0;
                        res.push_back(b);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        foreach (res[i])
            out_bytes_q.push_back(res[i]);
    endtask

    // returns at the posedge where the request is taken
    task automatic send_request(input logic [1:0] act, input logic [6:0] nbits,
                                input logic [2:0] nbytes, input logic [63:0] val);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, val, nbytes, nbits};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pack_request(act, nbits, nbytes, val);
    endtask

    // receive side with random stalls
    initial
    begin
        int        stall;
        out_byte_t exp;
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(snk_stall_max, 0);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (out_bytes_q.size() == 0)
            begin
                $display("%0t: unexpected byte %02h last %0b", $time, m_tdata, m_tlast);
                err_cnt++;
            end
            else
            begin
                exp = out_bytes_q.pop_front();
                if (m_tdata !== exp.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, exp.data, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== exp.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, exp.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_bit_writes;
        src_gap_max = 0;
        snk_stall_max = 0;
        send_request(ACT_WRITE_BITS, 7'd1, 3'd0, 64'h1);
        send_request(ACT_WRITE_BITS, 7'd7, 3'd7, 64'h7F);
        send_request(ACT_WRITE_BITS, 7'd0, 3'd0, '1);
        send_request(ACT_WRITE_BITS, 7'd64, 3'd0, '1);
        send_request(ACT_WRITE_BITS, 7'd64, 3'd0, '0);
        send_request(ACT_WRITE_BITS, 7'd3, 3'd0, 64'h5);
        send_request(ACT_WRITE_BITS, 7'd127, 3'd0, 64'hA5C3_0F1E_8877_2D4B);
        send_request(ACT_WRITE_BITS, 7'd13, 3'd0, 64'hFFFF_FFFF_FFFF_E9A6);
    endtask

    task automatic test_byte_writes;
        src_gap_max = 18;
        snk_stall_max = 18;
        send_request(ACT_WRITE_BYTES, 7'd0, 3'd4, 64'h1234_5678_9ABC_DEF0);
        send_request(ACT_WRITE_BITS, 7'd5, 3'd0, 64'h15);
        send_request(ACT_WRITE_BYTES, 7'd0, 3'd0, '1);
        send_request(ACT_WRITE_BYTES, 7'd0, 3'd7, '1);
        send_request(ACT_WRITE_BYTES, 7'd127, 3'd1, 64'hFF);
        send_request(ACT_WRITE_BYTES, 7'd0, 3'd2, '0);
        send_request(ACT_WRITE_BYTES, 7'd0, 3'd0, '0);
    endtask

    task automatic test_flushes;
        src_gap_max = 0;
        snk_stall_max = 18;
        send_request(ACT_FLUSH, 7'd0, 3'd0, '0);
        send_request(ACT_WRITE_BITS, 7'd8, 3'd0, 64'hFF);
        send_request(ACT_WRITE_BITS, 7'd2, 3'd0, 64'h0);
        send_request(ACT_FLUSH, 7'd127, 3'd7, '1);
        send_request(ACT_FLUSH, 7'd0, 3'd0, '0);
    endtask

    task automatic test_ignored;
        src_gap_max = 18;
        snk_stall_max = 0;
        send_request(ACT_WRITE_BITS, 7'd4, 3'd0, 64'h9);
        send_request(ACT_UNUSED, 7'd127, 3'd7, '1);
        send_request(ACT_WRITE_BITS, 7'd4, 3'd0, 64'h6);
    endtask

    task automatic test_random;
        int          cnt;
        int          sel;
        int          r;
        logic [1:0]  act;
        logic [6:0]  nbits;
        logic [2:0]  nbytes;
        logic [63:0] val;
        cnt = 0;
        while (cnt < RANDOM_REQUESTS)
        begin
            // change idling profile every 30 requests that are not dropped
            if (cnt % 30 == 0)
            begin
                src_gap_max = ($urandom_range(1, 0) == 1) ? 18 : 0;
                snk_stall_max = ($urandom_range(1, 0) == 1) ? 18 : 0;
            end
            sel = $urandom_range(99, 0);
            r = $urandom_range(9, 0);
            val = {$urandom, $urandom};
            if ($urandom_range(9, 0) == 0)
                val = ($urandom_range(1, 0) == 1) ? '1 : '0;
            nbits = 7'($urandom_range(127, 0));
            nbytes = 3'($urandom_range(7, 0));
            if (sel < 60)
            begin
                act = ACT_WRITE_BITS;
                if (r < 6)
                    nbits = 7'($urandom_range(16, 1));
                else if (r < 8)
                    nbits = 7'($urandom_range(64, 17));
                else if (r == 8)
                    nbits = 7'($urandom_range(127, 65));
                else
                    nbits = 7'd0;
            end
            else if (sel < 80)
            begin
                act = ACT_WRITE_BYTES;
                if (r < 7)
                    nbytes = 3'($urandom_range(MaxBytes, 1));
            end
            else if (sel < 95)
                act = ACT_FLUSH;
            else
                act = ACT_UNUSED;
            send_request(act, nbits, nbytes, val);
            if (act != ACT_UNUSED && !(act == ACT_WRITE_BITS && nbits == 7'd0))
                cnt++;
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        test_bit_writes();
        test_byte_writes();
        test_flushes();
        test_ignored();
        test_random();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (out_bytes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
